@@ rtl/pid_conditional_antiwindup_macros.svh @@
// Assertion macros used by the PID controller checker.
`ifndef PID_CONDITIONAL_ANTIWINDUP_MACROS_SVH
`define PID_CONDITIONAL_ANTIWINDUP_MACROS_SVH

// same-cycle implication, reset masks the check
`define PCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define PCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pid_ca_pkg.sv @@
// Shared constants, types and helpers of the PID controller.
`default_nettype none
package pid_ca_pkg;

  localparam int VALUE_WIDTH_DEF    = 32;
  localparam int FRAC_BITS_DEF      = 16;
  localparam int STEP_WIDTH_DEF     = 24;
  localparam int INTEGRAL_WIDTH_DEF = 48;

  localparam int TERM_W  = 62;
  localparam int SUM_W   = 64;
  localparam int DIGIT_W = 16;
  localparam int DIV_BITS = 4;

  function automatic int max3(input int a, input int b, input int c);
    int m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_INC
  } mul_op_t;

  typedef struct packed {
    logic    decode;
    logic    mul_start;
    mul_op_t mul_op;
    logic    div_start;
    logic    decide;
    logic    integ_upd;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic is_clear;
    logic dt_zero;
    logic first;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/pid_ca_div.sv @@
// Restoring divider, DIV_BITS quotient bits per iteration step.
`default_nettype none
module pid_ca_div #(
  parameter int DVD_W = 96,
  parameter int DVS_W = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int STEPS = DVD_W / pid_ca_pkg::DIV_BITS;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             busy;

  logic [DVD_W-1:0] dvd_next;
  logic [DVD_W-1:0] q_next;
  logic [DVS_W-1:0] rem_next;

  always_comb begin
    logic [DVS_W:0] trial;
    dvd_next = dvd;
    q_next   = quotient;
    rem_next = rem;
    for (int k = 0; k < pid_ca_pkg::DIV_BITS; k++) begin
      trial    = {rem_next, dvd_next[DVD_W-1]};
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial  = trial - {1'b0, divisor};
        q_next = {q_next[DVD_W-2:0], 1'b1};
      end else begin
        q_next = {q_next[DVD_W-2:0], 1'b0};
      end
      rem_next = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy     <= 1'b1;
      cnt      <= '0;
      dvd      <= dividend;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= dvd_next;
      rem      <= rem_next;
      quotient <= q_next;
      cnt      <= cnt + 1'b1;
      if (cnt == CW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/pid_ca_mul.sv @@
// Sign-magnitude multiplier, one 16-bit digit of the multiplier per cycle.
`default_nettype none
module pid_ca_mul #(
  parameter int OPW = 48,
  parameter int MP  = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic signed [OPW-1:0] a,
  input  wire logic signed [OPW-1:0] b,
  output logic                       done,
  output logic                       neg,
  output logic [2*MP-1:0]            prod_mag
);

  localparam int DW    = pid_ca_pkg::DIGIT_W;
  localparam int STEPS = MP / DW;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [MP-1:0] a_mag;
  logic [MP-1:0] b_sh;
  logic [CW-1:0] cnt;
  logic          busy;

  logic signed [OPW-1:0] a_neg;
  logic signed [OPW-1:0] b_neg;
  logic [MP-1:0]         a_abs;
  logic [MP-1:0]         b_abs;
  logic [MP+DW-1:0]      part;
  logic [MP+DW-1:0]      sum;

  assign a_neg = -a;
  assign b_neg = -b;
  assign a_abs = a[OPW-1] ? MP'($unsigned(a_neg)) : MP'($unsigned(a));
  assign b_abs = b[OPW-1] ? MP'($unsigned(b_neg)) : MP'($unsigned(b));
  assign part  = a_mag * b_sh[DW-1:0];
  assign sum   = {{DW{1'b0}}, prod_mag[2*MP-1:MP]} + part;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy     <= 1'b1;
      cnt      <= '0;
      a_mag    <= a_abs;
      b_sh     <= b_abs;
      neg      <= a[OPW-1] ^ b[OPW-1];
      prod_mag <= '0;
    end else if (busy) begin
      prod_mag <= {sum, prod_mag[MP-1:DW]};
      b_sh     <= b_sh >> DW;
      cnt      <= cnt + 1'b1;
      if (cnt == CW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/pid_ca_dp.sv @@
// PID datapath: controller state, term registers, shared multiplier and divider.
`default_nettype none
module pid_ca_dp #(
  parameter int VALUE_WIDTH    = pid_ca_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS      = pid_ca_pkg::FRAC_BITS_DEF,
  parameter int STEP_WIDTH     = pid_ca_pkg::STEP_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = pid_ca_pkg::INTEGRAL_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_fire,
  input  wire logic                          req_type,
  input  wire logic signed [VALUE_WIDTH-1:0] target_value,
  input  wire logic signed [VALUE_WIDTH-1:0] measured_value,
  input  wire logic [STEP_WIDTH-1:0]         time_step,
  input  wire logic signed [VALUE_WIDTH-1:0] gain_p,
  input  wire logic signed [VALUE_WIDTH-1:0] gain_i,
  input  wire logic signed [VALUE_WIDTH-1:0] gain_d,
  input  wire logic signed [VALUE_WIDTH-1:0] limit_low,
  input  wire logic signed [VALUE_WIDTH-1:0] limit_high,
  input  wire logic                          limits_enable,
  input  wire pid_ca_pkg::dp_cmd_t           cmd,
  output pid_ca_pkg::dp_stat_t               stat,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0]      drive_value,
  output logic                               integration_held,
  output logic                               step_rejected
);

  localparam int TW   = pid_ca_pkg::TERM_W;
  localparam int SW   = pid_ca_pkg::SUM_W;
  localparam int EW   = VALUE_WIDTH + 1;
  localparam int DFW  = VALUE_WIDTH + 2;
  localparam int OPW  = pid_ca_pkg::max3(INTEGRAL_WIDTH, DFW, STEP_WIDTH + 1);
  localparam int MP   = ((OPW + pid_ca_pkg::DIGIT_W - 1) / pid_ca_pkg::DIGIT_W)
                        * pid_ca_pkg::DIGIT_W;
  localparam int PW   = 2 * MP + 1;
  localparam int AW   = ((INTEGRAL_WIDTH > TW) ? INTEGRAL_WIDTH : TW) + 1;

  function automatic logic signed [TW-1:0] sat_term(input logic signed [PW-1:0] v);
    if ((&v[PW-1:TW-1]) || !(|v[PW-1:TW-1])) return v[TW-1:0];
    return v[PW-1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
  endfunction

  function automatic logic signed [INTEGRAL_WIDTH-1:0] sat_integ(
      input logic signed [AW-1:0] v);
    if ((&v[AW-1:INTEGRAL_WIDTH-1]) || !(|v[AW-1:INTEGRAL_WIDTH-1]))
      return v[INTEGRAL_WIDTH-1:0];
    return v[AW-1] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
                   : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
  endfunction

  logic                          req_r;
  logic signed [VALUE_WIDTH-1:0] tgt_r;
  logic signed [VALUE_WIDTH-1:0] meas_r;
  logic [STEP_WIDTH-1:0]         dt_r;

  logic signed [EW-1:0]             err;
  logic signed [DFW-1:0]            diff;
  logic signed [EW-1:0]             last_err;
  logic                             first;
  logic                             first_snap;
  logic signed [INTEGRAL_WIDTH-1:0] integral;
  logic signed [TW-1:0]             p_term;
  logic signed [TW-1:0]             i_term;
  logic signed [TW-1:0]             d_term;
  logic signed [TW-1:0]             inc;
  logic                             held;

  logic signed [EW-1:0]  err_c;
  logic signed [DFW-1:0] diff_c;
  assign err_c  = EW'(tgt_r) - EW'(meas_r);
  assign diff_c = DFW'(err_c) - DFW'(last_err);

  logic signed [OPW-1:0] op_a;
  logic signed [OPW-1:0] op_b;
  always_comb begin
    unique case (cmd.mul_op)
      pid_ca_pkg::MUL_P: begin
        op_a = OPW'(gain_p);
        op_b = OPW'(err);
      end
      pid_ca_pkg::MUL_I: begin
        op_a = OPW'(gain_i);
        op_b = OPW'(integral);
      end
      pid_ca_pkg::MUL_D: begin
        op_a = OPW'(gain_d);
        op_b = OPW'(diff);
      end
      pid_ca_pkg::MUL_INC: begin
        op_a = OPW'(err);
        op_b = OPW'($signed({1'b0, dt_r}));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  logic            mul_done;
  logic            mul_neg;
  logic [2*MP-1:0] prod_mag;
  logic            div_done;
  logic [2*MP-1:0] quot;

  pid_ca_mul #(.OPW(OPW), .MP(MP)) u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mul_start),
    .a        (op_a),
    .b        (op_b),
    .done     (mul_done),
    .neg      (mul_neg),
    .prod_mag (prod_mag)
  );

  pid_ca_div #(.DVD_W(2 * MP), .DVS_W(STEP_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_mag),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (quot)
  );

  logic signed [PW-1:0] prod_s;
  logic signed [PW-1:0] quot_s;
  assign prod_s = mul_neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
  assign quot_s = mul_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  logic signed [SW-1:0] sum3;
  logic signed [SW-1:0] lim_hi;
  logic signed [SW-1:0] lim_lo;
  logic signed [SW-1:0] clamped;
  logic signed [VALUE_WIDTH-1:0] out_c;
  logic err_pos;
  logic err_neg;

  assign sum3    = SW'(p_term) + SW'(i_term) + SW'(d_term);
  assign lim_hi  = SW'(limit_high);
  assign lim_lo  = SW'(limit_low);
  assign err_neg = err[EW-1];
  assign err_pos = !err[EW-1] && (|err);

  always_comb begin
    clamped = sum3;
    if (limits_enable) begin
      priority if (sum3 > lim_hi) clamped = lim_hi;
      else if (sum3 < lim_lo) clamped = lim_lo;
    end
    if ((&clamped[SW-1:VALUE_WIDTH-1]) || !(|clamped[SW-1:VALUE_WIDTH-1]))
      out_c = clamped[VALUE_WIDTH-1:0];
    else
      out_c = clamped[SW-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                            : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= req_type;
      tgt_r  <= target_value;
      meas_r <= measured_value;
      dt_r   <= time_step;
    end
    if (mul_done) begin
      unique case (cmd.mul_op)
        pid_ca_pkg::MUL_P:   p_term <= sat_term(prod_s >>> FRAC_BITS);
        pid_ca_pkg::MUL_I:   i_term <= sat_term(prod_s >>> FRAC_BITS);
        pid_ca_pkg::MUL_INC: inc    <= sat_term(prod_s >>> FRAC_BITS);
        default: ;
      endcase
    end
    if (div_done) d_term <= sat_term(quot_s);
    if (cmd.decode) begin
      err        <= err_c;
      diff       <= diff_c;
      first_snap <= first;
      d_term     <= '0;
    end
    if (cmd.decide)
      held <= limits_enable && ((sum3 > lim_hi && err_pos) || (sum3 < lim_lo && err_neg));
    if (cmd.finish) begin
      drive_value      <= '0;
      integration_held <= 1'b0;
      step_rejected    <= 1'b0;
      if (!req_r) begin
        if (dt_r == '0) begin
          step_rejected <= 1'b1;
        end else begin
          drive_value      <= out_c;
          integration_held <= held;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral  <= '0;
      last_err  <= '0;
      first     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decode) begin
        if (req_r) begin
          integral <= '0;
          last_err <= '0;
          first    <= 1'b1;
        end else if (dt_r != '0) begin
          last_err <= err_c;
          first    <= 1'b0;
        end
      end
      if (cmd.integ_upd && !held)
        integral <= sat_integ(AW'(integral) + AW'(inc));
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.is_clear = req_r;
  assign stat.dt_zero  = (dt_r == '0);
  assign stat.first    = first_snap;
  assign stat.out_free = !out_valid;

endmodule
`default_nettype wire

@@ rtl/pid_ca_ctrl.sv @@
// PID sequencer: orders the multiplies, the divide and the result load.
`default_nettype none
module pid_ca_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pid_ca_pkg::dp_stat_t stat,
  output pid_ca_pkg::dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_DIV_D,
    S_DECIDE,
    S_MUL_INC,
    S_UPDATE,
    S_MUL_I2,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd   <= '0;
    end else begin
      cmd.decode    <= 1'b0;
      cmd.mul_start <= 1'b0;
      cmd.div_start <= 1'b0;
      cmd.decide    <= 1'b0;
      cmd.integ_upd <= 1'b0;
      cmd.finish    <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd.decode <= 1'b1;
            state      <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (stat.is_clear || stat.dt_zero) begin
            state <= S_FINISH;
          end else begin
            cmd.mul_start <= 1'b1;
            cmd.mul_op    <= pid_ca_pkg::MUL_P;
            state         <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          if (stat.mul_done) begin
            cmd.mul_start <= 1'b1;
            cmd.mul_op    <= pid_ca_pkg::MUL_I;
            state         <= S_MUL_I;
          end
        end
        S_MUL_I: begin
          if (stat.mul_done) begin
            if (stat.first) begin
              cmd.decide <= 1'b1;
              state      <= S_DECIDE;
            end else begin
              cmd.mul_start <= 1'b1;
              cmd.mul_op    <= pid_ca_pkg::MUL_D;
              state         <= S_MUL_D;
            end
          end
        end
        S_MUL_D: begin
          if (stat.mul_done) begin
            cmd.div_start <= 1'b1;
            state         <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          if (stat.div_done) begin
            cmd.decide <= 1'b1;
            state      <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cmd.mul_start <= 1'b1;
          cmd.mul_op    <= pid_ca_pkg::MUL_INC;
          state         <= S_MUL_INC;
        end
        S_MUL_INC: begin
          if (stat.mul_done) begin
            cmd.integ_upd <= 1'b1;
            state         <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          cmd.mul_start <= 1'b1;
          cmd.mul_op    <= pid_ca_pkg::MUL_I;
          state         <= S_MUL_I2;
        end
        S_MUL_I2: begin
          if (stat.mul_done) state <= S_FINISH;
        end
        S_FINISH: begin
          if (stat.out_free) begin
            cmd.finish <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/pid_conditional_antiwindup.sv @@
// PID controller with conditional-integration anti-windup: top level.
//
// Input beats arrive on s_*: tuser carries the request kind (compute or
// clear), tdata the setpoint, measurement and time step. Each beat yields
// exactly one result beat on m_*: tdata the drive value, tuser the
// integration-held and step-rejected flags.
// Gains, limits and the limit enable sit behind the APB port; write them
// only while no beat is in flight.
// One beat is processed at a time. A compute beat skips the derivative on
// the first step after a clear; clear and zero-step beats go straight to
// the result load. The next beat is accepted in the cycle the result is
// loaded. The time of a compute beat is set by up to five passes through
// the shared 48x16 multiplier and the divide of the derivative term, 4
// quotient bits per cycle over the 96-bit product.
// Reset zeroes the settings, integral and previous error, and arms the
// first-step flag. A stalled result holds in the output register; the next
// beat is accepted and worked on, and waits before its result is loaded.
`default_nettype none
module pid_conditional_antiwindup #(
  parameter int VALUE_WIDTH    = pid_ca_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS      = pid_ca_pkg::FRAC_BITS_DEF,
  parameter int STEP_WIDTH     = pid_ca_pkg::STEP_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = pid_ca_pkg::INTEGRAL_WIDTH_DEF,
  localparam int IN_DW   = ((2 * VALUE_WIDTH + STEP_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW  = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int CFG_DW  = (VALUE_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_LSB = (VALUE_WIDTH > 32) ? 3 : 2,
  localparam int ADDR_W  = ADDR_LSB + 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // target_value, measured_value, time_step
  input  wire logic [IN_DW-1:0]  s_tdata,
  // req_type
  input  wire logic              s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // drive_value
  output logic [OUT_DW-1:0]      m_tdata,
  // integration_held, step_rejected
  output logic [1:0]             m_tuser,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_LIMIT_LOW,
    REG_LIMIT_HIGH,
    REG_LIMITS_ENABLE
  } reg_idx_t;

  logic signed [VALUE_WIDTH-1:0] gain_p;
  logic signed [VALUE_WIDTH-1:0] gain_i;
  logic signed [VALUE_WIDTH-1:0] gain_d;
  logic signed [VALUE_WIDTH-1:0] limit_low;
  logic signed [VALUE_WIDTH-1:0] limit_high;
  logic                          limits_enable;

  logic [2:0] reg_idx;
  assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      limit_low     <= '0;
      limit_high    <= '0;
      limits_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_GAIN_P:        gain_p        <= pwdata[VALUE_WIDTH-1:0];
        REG_GAIN_I:        gain_i        <= pwdata[VALUE_WIDTH-1:0];
        REG_GAIN_D:        gain_d        <= pwdata[VALUE_WIDTH-1:0];
        REG_LIMIT_LOW:     limit_low     <= pwdata[VALUE_WIDTH-1:0];
        REG_LIMIT_HIGH:    limit_high    <= pwdata[VALUE_WIDTH-1:0];
        REG_LIMITS_ENABLE: limits_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_P:        prdata = CFG_DW'($unsigned(gain_p));
      REG_GAIN_I:        prdata = CFG_DW'($unsigned(gain_i));
      REG_GAIN_D:        prdata = CFG_DW'($unsigned(gain_d));
      REG_LIMIT_LOW:     prdata = CFG_DW'($unsigned(limit_low));
      REG_LIMIT_HIGH:    prdata = CFG_DW'($unsigned(limit_high));
      REG_LIMITS_ENABLE: prdata = CFG_DW'(limits_enable);
      default:           prdata = '0;
    endcase
  end

  pid_ca_pkg::dp_cmd_t  cmd;
  pid_ca_pkg::dp_stat_t stat;

  logic signed [VALUE_WIDTH-1:0] drive_value;
  logic                          integration_held;
  logic                          step_rejected;

  pid_ca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pid_ca_dp #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .FRAC_BITS      (FRAC_BITS),
    .STEP_WIDTH     (STEP_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .in_fire          (s_tvalid && s_tready),
    .req_type         (s_tuser),
    .target_value     (s_tdata[VALUE_WIDTH-1:0]),
    .measured_value   (s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
    .time_step        (s_tdata[2*VALUE_WIDTH+STEP_WIDTH-1:2*VALUE_WIDTH]),
    .gain_p           (gain_p),
    .gain_i           (gain_i),
    .gain_d           (gain_d),
    .limit_low        (limit_low),
    .limit_high       (limit_high),
    .limits_enable    (limits_enable),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .drive_value      (drive_value),
    .integration_held (integration_held),
    .step_rejected    (step_rejected)
  );

  assign m_tdata = OUT_DW'($unsigned(drive_value));
  assign m_tuser = {step_rejected, integration_held};

endmodule
`default_nettype wire

@@ rtl/pid_ca_checker.sv @@
// Port-level checks of the PID controller, bound to the top level.
`default_nettype none
`include "pid_conditional_antiwindup_macros.svh"
module pid_ca_checker #(
  parameter int OUT_DW = 32
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [OUT_DW-1:0] m_tdata,
  input wire logic [1:0]        m_tuser
);

  `PCA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `PCA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "beat accepted while busy")
  `PCA_ASSERT_NOW(a_flags_exclusive, m_tvalid, !(m_tuser[0] && m_tuser[1]), "held and rejected both set")
  `PCA_ASSERT_NOW(a_reject_zero, m_tvalid && m_tuser[1], m_tdata == '0, "rejected step with nonzero drive")

endmodule

bind pid_conditional_antiwindup pid_ca_checker #(.OUT_DW(OUT_DW)) u_pid_ca_checker (.*);
`default_nettype wire
